[hdl/dwt_pkg.sv]
// Package for the deadline wakeup table: states, shared-unit request type,
// operation and result codes, fixed field widths. No dependencies.
package dwt_pkg;

  localparam int CLK_W    = 64;
  localparam int DELAY_W  = 32;
  localparam int PERIOD_W = 10;
  localparam int PID_W    = 16;
  localparam int KIND_W   = 2;
  localparam int ADDR_W   = 2;
  localparam int DATA_W   = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

  // APB register map
  localparam logic [ADDR_W-1:0] ADDR_TICK_PERIOD = 2'd0;

  // input operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WAKE     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUIET    = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_TICK_ADV,
    ST_TICK_SCAN,
    ST_TICK_DRAIN,
    ST_TICK_DONE
  } dwt_state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [CLK_W-1:0]   a;
    logic [CLK_W-1:0]   b;
  } alu_req_t;

endpackage

[hdl/dwt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dwt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/dwt_alu.sv]
// Shared 64-bit add / subtract unit; the subtract carry gives an unsigned a >= b.
// Depends on dwt_pkg.
module dwt_alu
  import dwt_pkg::*;
(
  input  alu_req_t           req,
  output logic [CLK_W-1:0]   sum,
  output logic               ge
);

  logic [CLK_W-1:0] b_eff;
  logic [CLK_W:0]   full;
  logic             cin;

  always_comb begin
    cin   = (req.op == ALU_SUB);
    b_eff = cin ? ~req.b : req.b;
    full  = {1'b0, req.a} + {1'b0, b_eff} + {{CLK_W{1'b0}}, cin};
  end

  assign sum = full[CLK_W-1:0];
  // carry out on a - b means no borrow
  assign ge  = full[CLK_W];

endmodule

[hdl/deadline_wakeup_table_core.sv]
// Top level of the deadline wakeup table: sequencer, slot valid bits, clock,
// APB register. Depends on dwt_pkg, dwt_alu, dwt_ram.
//
//  port group  | direction | handshake                 | payload
//  ------------+-----------+---------------------------+---------------------------------
//  in_*        | in        | start & !busy             | operation, process_id, delay_ms
//  out_*       | out       | out_strobe, one cycle     | kind, wake_pid, time_now, final_item
//  APB         | in/out    | psel & penable, pready=1  | tick period at address 0
//
// Add: examines one slot per cycle until the lowest free slot or the last slot;
// the result shows on the cycle after. Tick: advances the clock (ST_TICK_ADV), reads
// every slot through the single RAM read port (ST_TICK_SCAN), then drains and closes
// (ST_TICK_DRAIN, ST_TICK_DONE). Both use the one shared 64-bit adder.
// rst_n (sync) clears the clock, the valid bits and the period to 10; slot RAM
// contents are not cleared. Results cannot be stalled; busy holds off new words.
module deadline_wakeup_table_core
  import dwt_pkg::*;
#(
  parameter int SLOTS    = 16,
  parameter int PID_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_operation,
  input  logic [PID_W-1:0]     in_process_id,
  input  logic [DELAY_W-1:0]   in_delay_ms,
  // result channel
  output logic                 out_strobe,
  output logic [KIND_W-1:0]    out_kind,
  output logic [PID_W-1:0]     out_wake_pid,
  output logic [CLK_W-1:0]     out_time_now,
  output logic                 out_final_item,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_W-1:0]    paddr,
  input  logic [DATA_W-1:0]    pwdata,
  output logic [DATA_W-1:0]    prdata,
  output logic                 pready
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int RAM_W = CLK_W + PID_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  dwt_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CLK_W-1:0]    clock_r, clock_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic [PID_BITS-1:0] pid_r;
  logic [DELAY_W-1:0]  delay_r;
  logic [SLOTS-1:0]    used_r, used_nxt;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;
  logic                pend_r, pend_nxt;
  logic [PID_BITS-1:0] pend_pid_r, pend_pid_nxt;

  logic                out_strobe_r;
  logic [KIND_W-1:0]   out_kind_r;
  logic [PID_W-1:0]    out_wake_pid_r;
  logic [CLK_W-1:0]    out_time_now_r;
  logic                out_final_r;

  logic                accept;
  logic                cfg_wr;
  logic                emit;
  logic [KIND_W-1:0]   emit_kind;
  logic [PID_BITS-1:0] emit_pid;
  logic                emit_final;
  logic                hit;

  alu_req_t            alu_req;
  logic [CLK_W-1:0]    alu_sum;
  logic                alu_ge;

  logic                ram_we;
  logic [RAM_W-1:0]    ram_wdata;
  logic [RAM_W-1:0]    ram_rdata;
  logic [CLK_W-1:0]    rd_deadline;
  logic [PID_BITS-1:0] rd_pid;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // ---------------- APB register ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TICK_PERIOD);
  assign prdata = (paddr == ADDR_TICK_PERIOD) ? DATA_W'(period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr) begin
      period_r <= pwdata[PERIOD_W-1:0];
    end
  end

  // ---------------- shared unit and slot RAM ----------------
  assign rd_deadline = ram_rdata[RAM_W-1:PID_BITS];
  assign rd_pid      = ram_rdata[PID_BITS-1:0];

  always_comb begin
    alu_req.a = clock_r;
    unique case (state_r)
      ST_ADD_SCAN: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = CLK_W'(delay_r);
      end
      ST_TICK_ADV: begin
        alu_req.op = ALU_ADD;
        alu_req.b  = CLK_W'(period_r);
      end
      default: begin
        alu_req.op = ALU_SUB;
        alu_req.b  = rd_deadline;
      end
    endcase
  end

  dwt_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .ge  (alu_ge)
  );

  assign ram_we    = (state_r == ST_ADD_SCAN) && !used_r[idx_r];
  assign ram_wdata = {alu_sum, pid_r};

  dwt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer: next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_operation == OP_TICK) ? ST_TICK_ADV : ST_ADD_SCAN;
        end
      end
      ST_ADD_SCAN: begin
        if (!used_r[idx_r] || idx_r == LAST_IDX) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_TICK_ADV:   state_nxt = ST_TICK_SCAN;
      ST_TICK_SCAN: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = ST_TICK_DRAIN;
        end
      end
      ST_TICK_DRAIN: state_nxt = ST_TICK_DONE;
      ST_TICK_DONE:  state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: datapath controls ----------------
  // a wakeup is held back until the next one or the close of the tick, so the last one of a tick can carry final_item
  assign hit = rd_vld_r && used_r[rd_idx_r] && alu_ge;

  always_comb begin
    idx_nxt      = idx_r;
    clock_nxt    = clock_r;
    used_nxt     = used_r;
    pend_nxt     = pend_r;
    pend_pid_nxt = pend_pid_r;
    emit         = 1'b0;
    emit_kind    = KIND_ADD_OK;
    emit_pid     = '0;
    emit_final   = 1'b1;

    if (hit) begin
      used_nxt[rd_idx_r] = 1'b0;
      pend_nxt           = 1'b1;
      pend_pid_nxt       = rd_pid;
      if (pend_r) begin
        emit       = 1'b1;
        emit_kind  = KIND_WAKE;
        emit_pid   = pend_pid_r;
        emit_final = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        idx_nxt = '0;
      end
      ST_ADD_SCAN: begin
        if (!used_r[idx_r]) begin
          used_nxt[idx_r] = 1'b1;
          emit            = 1'b1;
          emit_kind       = KIND_ADD_OK;
        end else if (idx_r == LAST_IDX) begin
          emit      = 1'b1;
          emit_kind = KIND_ADD_FULL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TICK_ADV: begin
        clock_nxt = alu_sum;
        pend_nxt  = 1'b0;
        idx_nxt   = '0;
      end
      ST_TICK_SCAN: begin
        if (idx_r != LAST_IDX) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_TICK_DRAIN: begin
      end
      ST_TICK_DONE: begin
        emit       = 1'b1;
        emit_final = 1'b1;
        emit_kind  = pend_r ? KIND_WAKE : KIND_QUIET;
        emit_pid   = pend_r ? pend_pid_r : '0;
        pend_nxt   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idx_r        <= '0;
      clock_r      <= '0;
      used_r       <= '0;
      rd_vld_r     <= 1'b0;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      clock_r      <= clock_nxt;
      used_r       <= used_nxt;
      rd_vld_r     <= (state_r == ST_TICK_SCAN);
      pend_r       <= pend_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pid_r   <= PID_BITS'(in_process_id);
      delay_r <= in_delay_ms;
    end
    rd_idx_r       <= idx_r;
    pend_pid_r     <= pend_pid_nxt;
    out_kind_r     <= emit_kind;
    out_wake_pid_r <= PID_W'(emit_pid);
    out_time_now_r <= clock_r;
    out_final_r    <= emit_final;
  end

  assign out_strobe     = out_strobe_r;
  assign out_kind       = out_kind_r;
  assign out_wake_pid   = out_wake_pid_r;
  assign out_time_now   = out_time_now_r;
  assign out_final_item = out_final_r;

  // ---------------- assertions ----------------
  a_word_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without a command in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not start the sequencer");

  a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_kind == KIND_ADD_FULL) |-> (&used_r))
    else $error("add rejected while a slot is free");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_final_item) |=> !out_strobe)
    else $error("result word right after the final word of a command");

endmodule
